### sv/ucd_pkg.sv
`timescale 1ns / 1ps

package ucd_pkg;

  localparam logic [7:0] START_MARKER_RST = 8'hAA;

  localparam logic [7:0] SENSOR_FIRST = 8'h01;
  localparam logic [7:0] SENSOR_LAST  = 8'h03;

  localparam logic [7:0] TYPE_RELAY = 8'h10;
  localparam logic [7:0] TYPE_LED   = 8'h11;
  localparam logic [7:0] TYPE_SERVO = 8'h12;
  localparam logic [7:0] TYPE_LCD   = 8'h13;

  typedef enum logic [2:0] {
    ACT_RELAY     = 3'd0,
    ACT_LED_DUTY  = 3'd1,
    ACT_SERVO     = 3'd2,
    ACT_LCD_CLEAR = 3'd3,
    ACT_LCD_CHAR  = 3'd4,
    ACT_SENSOR    = 3'd5
  } action_e;

  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic last;
  } sts_t;

endpackage

### sv/ucd_ctrl.sv
`timescale 1ns / 1ps

module ucd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  input  ucd_pkg::sts_t sts_i,
  output ucd_pkg::cmd_t cmd_o
);

  typedef enum logic {
    ST_RX,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   m_valid_q;

  assign s_ready_o     = (state_q == ST_RX);
  assign m_valid_o     = m_valid_q;
  assign cmd_o.accept  = s_valid_i && (state_q == ST_RX);
  assign cmd_o.load    = (state_q == ST_EMIT) && (!m_valid_q || m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RX;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_RX: begin
          if (cmd_o.accept && sts_i.has_result) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd_o.load && sts_i.last) begin
            state_q <= ST_RX;
          end
        end
        default: state_q <= ST_RX;
      endcase
    end
  end

endmodule

### sv/ucd_dpath.sv
`timescale 1ns / 1ps

module ucd_dpath #(
  parameter int PAYLOAD_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       rx_byte_i,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_data_i,
  input  ucd_pkg::cmd_t    cmd_i,
  output ucd_pkg::sts_t    sts_o,
  output ucd_pkg::action_e action_o,
  output logic [7:0]       value_o,
  output logic             last_o
);

  localparam int AddrW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int CntW  = $clog2(PAYLOAD_DEPTH + 1);
  localparam logic [8:0]      Depth9   = 9'(PAYLOAD_DEPTH);
  localparam logic [CntW-1:0] DepthCnt = CntW'(PAYLOAD_DEPTH);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_LEN,
    PH_DATA,
    PH_CHECK
  } phase_e;

  phase_e     phase_q;
  logic [7:0] marker_q;
  logic [7:0] type_q;
  logic [7:0] len_q;
  logic [7:0] count_q;
  logic [7:0] xor_q;

  logic [7:0] mem [PAYLOAD_DEPTH];
  logic [7:0] rd_q;

  ucd_pkg::action_e em_act_q;
  logic [7:0]       em_byte_q;
  logic [CntW-1:0]  em_len_q;
  logic [CntW-1:0]  idx_q;
  logic [CntW-1:0]  ptr_q;
  logic [CntW-1:0]  ptr_d;

  ucd_pkg::action_e out_act_q;
  logic [7:0]       out_val_q;
  logic             out_last_q;

  logic             len_ok;
  logic             type_ok;
  logic             sensor_hit;
  logic             packet_good;
  ucd_pkg::action_e first_act;
  ucd_pkg::action_e res_act;
  logic [7:0]       res_val;
  logic             res_last;
  logic [7:0]       count_inc;

  assign count_inc = count_q + 8'd1;
  assign len_ok    = {1'b0, len_q} <= Depth9;

  always_comb begin
    type_ok   = 1'b0;
    first_act = ucd_pkg::ACT_SENSOR;
    unique case (type_q)
      ucd_pkg::TYPE_RELAY: begin
        type_ok   = (len_q != 8'd0);
        first_act = ucd_pkg::ACT_RELAY;
      end
      ucd_pkg::TYPE_LED: begin
        type_ok   = (len_q != 8'd0);
        first_act = ucd_pkg::ACT_LED_DUTY;
      end
      ucd_pkg::TYPE_SERVO: begin
        type_ok   = (len_q != 8'd0);
        first_act = ucd_pkg::ACT_SERVO;
      end
      ucd_pkg::TYPE_LCD: begin
        type_ok   = 1'b1;
        first_act = ucd_pkg::ACT_LCD_CLEAR;
      end
      default: begin
        type_ok   = 1'b0;
        first_act = ucd_pkg::ACT_SENSOR;
      end
    endcase
  end

  assign sensor_hit  = (phase_q == PH_IDLE) && (rx_byte_i != marker_q) &&
                       (rx_byte_i >= ucd_pkg::SENSOR_FIRST) &&
                       (rx_byte_i <= ucd_pkg::SENSOR_LAST);
  assign packet_good = (phase_q == PH_CHECK) && (rx_byte_i == xor_q) && len_ok && type_ok;

  assign sts_o.has_result = sensor_hit || packet_good;
  assign sts_o.last       = res_last;

  always_comb begin
    res_act  = em_act_q;
    res_val  = rd_q;
    res_last = 1'b1;
    if (em_act_q == ucd_pkg::ACT_LCD_CLEAR) begin
      if (idx_q == '0) begin
        res_act  = ucd_pkg::ACT_LCD_CLEAR;
        res_val  = 8'd0;
        res_last = (em_len_q == '0);
      end else begin
        res_act  = ucd_pkg::ACT_LCD_CHAR;
        res_val  = rd_q;
        res_last = (idx_q == em_len_q);
      end
    end else if (em_act_q == ucd_pkg::ACT_RELAY) begin
      res_val = {7'd0, rd_q != 8'd0};
    end else if (em_act_q == ucd_pkg::ACT_SENSOR) begin
      res_val = em_byte_q;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.accept) begin
      ptr_d = '0;
    end else if (cmd_i.load && (em_act_q == ucd_pkg::ACT_LCD_CLEAR) && (idx_q != '0)) begin
      ptr_d = ptr_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      marker_q <= ucd_pkg::START_MARKER_RST;
      type_q   <= 8'd0;
      len_q    <= 8'd0;
      count_q  <= 8'd0;
      xor_q    <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        marker_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        unique case (phase_q)
          PH_TYPE: begin
            type_q  <= rx_byte_i;
            xor_q   <= rx_byte_i;
            phase_q <= PH_LEN;
          end
          PH_LEN: begin
            len_q   <= rx_byte_i;
            xor_q   <= xor_q ^ rx_byte_i;
            count_q <= 8'd0;
            phase_q <= (rx_byte_i == 8'd0) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            xor_q   <= xor_q ^ rx_byte_i;
            count_q <= count_inc;
            if (count_inc >= len_q) begin
              phase_q <= PH_CHECK;
            end
          end
          PH_CHECK: begin
            phase_q <= PH_IDLE;
          end
          default: begin
            phase_q <= (rx_byte_i == marker_q) ? PH_TYPE : PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (phase_q == PH_DATA) && ({1'b0, count_q} < Depth9)) begin
      mem[count_q[AddrW-1:0]] <= rx_byte_i;
    end
    if (ptr_d < DepthCnt) begin
      rd_q <= mem[ptr_d[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.accept) begin
      em_act_q  <= sensor_hit ? ucd_pkg::ACT_SENSOR : first_act;
      em_byte_q <= rx_byte_i;
      em_len_q  <= len_q[CntW-1:0];
      idx_q     <= '0;
    end else if (cmd_i.load) begin
      idx_q <= idx_q + CntW'(1);
    end
    if (cmd_i.load) begin
      out_act_q  <= res_act;
      out_val_q  <= res_val;
      out_last_q <= res_last;
    end
  end

  assign action_o = out_act_q;
  assign value_o  = out_val_q;
  assign last_o   = out_last_q;

endmodule

### sv/uart_command_deframer_unit.sv
`timescale 1ns / 1ps
// Serial command deframer. Received bytes enter on the s_axis channel, one
// byte per item. While no packet is open, a byte equal to the start marker
// opens one and bytes 1..3 give a sensor request; a packet is type, length,
// payload and an XOR check byte. Results leave on the m_axis channel as
// {value, action} in tdata, with tlast on the final result of an input byte.
// The start marker is written on the cfg channel (always ready); the user must
// write it only while the block is idle, as the block does not enforce this.
// Throughput: a byte that gives no result is taken and the input stays open.
// A byte that gives N results (up to PAYLOAD_DEPTH + 1 for LCD text) holds
// off the input while the results are loaded into the output register one
// per cycle when the receiver does not stall; the next byte may enter once
// the last result is in that register, even if it is not yet taken. The
// payload buffer is a memory with a registered read port, which sets the
// one-result-per-cycle pace.
// Reset clears the framing state to idle and the start marker to 0xAA; the
// payload buffer is not cleared. When the receiver stalls, the output
// register holds its item and result generation waits.
module uart_command_deframer_unit #(
  parameter int PAYLOAD_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] action, [10:3] value, [15:11] zero
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  ucd_pkg::cmd_t    cmd;
  ucd_pkg::sts_t    sts;
  ucd_pkg::action_e action;
  logic [7:0]       value;

  assign cfg_ready_o = 1'b1;

  ucd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ucd_dpath #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (s_axis_tdata),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .action_o   (action),
    .value_o    (value),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, value, action};

  a_emit_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept && sts.has_result |=> !s_axis_tready)
    else $error("input not held off while results are pending");

  a_last_reopens_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load && sts.last |=> s_axis_tready)
    else $error("input not reopened after final result");

  a_no_load_while_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !cmd.load)
    else $error("result loaded while receiving");

endmodule

### tb/sv/uart_command_deframer_unit_tb.sv
`timescale 1ns / 1ps

module uart_command_deframer_unit_tb;

  localparam int PAYLOAD_DEPTH = 16;
  localparam int DRAIN_CYCLES = PAYLOAD_DEPTH + 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 20;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_TYPE,
    FR_LEN,
    FR_DATA,
    FR_CHECK
  } frame_phase_e;

  typedef struct {
    ucd_pkg::action_e action;
    logic [7:0]       value;
    logic             last;
  } deframer_action_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;

  frame_phase_e frame_phase;
  logic [7:0]   start_marker;
  logic [7:0]   pkt_type;
  logic [7:0]   pkt_len;
  logic [7:0]   byte_cnt;
  logic [7:0]   run_xor;
  logic [7:0]   payload_buf [PAYLOAD_DEPTH];

  deframer_action_t expected_actions[$];
  deframer_action_t head_action;

  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int marker_writes = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  uart_command_deframer_unit #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_actions.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_actions.size() == 0) begin
        report_mismatch($sformatf("unexpected result action %0d value 0x%02h last %0b",
                                  m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tlast));
      end else begin
        head_action = expected_actions.pop_front();
        results_checked++;
        if (m_axis_tdata[2:0] !== head_action.action ||
            m_axis_tdata[10:3] !== head_action.value ||
            m_axis_tlast !== head_action.last) begin
          report_mismatch($sformatf(
            "got action %0d value 0x%02h last %0b, want action %0d value 0x%02h last %0b",
            m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tlast,
            head_action.action, head_action.value, head_action.last));
        end
      end
    end
  end

  function automatic void queue_action(input ucd_pkg::action_e act, input logic [7:0] val,
                                       input logic last);
    deframer_action_t r;
    r.action = act;
    r.value = val;
    r.last = last;
    expected_actions.push_back(r);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    case (frame_phase)
      FR_TYPE: begin
        pkt_type = b;
        run_xor = b;
        frame_phase = FR_LEN;
      end
      FR_LEN: begin
        pkt_len = b;
        run_xor = run_xor ^ b;
        byte_cnt = 8'd0;
        frame_phase = (b == 8'd0) ? FR_CHECK : FR_DATA;
      end
      FR_DATA: begin
        if (byte_cnt < PAYLOAD_DEPTH) payload_buf[byte_cnt] = b;
        run_xor = run_xor ^ b;
        byte_cnt = byte_cnt + 8'd1;
        if (byte_cnt >= pkt_len) frame_phase = FR_CHECK;
      end
      FR_CHECK: begin
        frame_phase = FR_IDLE;
        if (b == run_xor && pkt_len <= PAYLOAD_DEPTH) begin
          case (pkt_type)
            ucd_pkg::TYPE_RELAY:
              if (pkt_len != 0)
                queue_action(ucd_pkg::ACT_RELAY, (payload_buf[0] != 8'd0) ? 8'd1 : 8'd0,
                             1'b1);
            ucd_pkg::TYPE_LED:
              if (pkt_len != 0) queue_action(ucd_pkg::ACT_LED_DUTY, payload_buf[0], 1'b1);
            ucd_pkg::TYPE_SERVO:
              if (pkt_len != 0) queue_action(ucd_pkg::ACT_SERVO, payload_buf[0], 1'b1);
            ucd_pkg::TYPE_LCD: begin
              queue_action(ucd_pkg::ACT_LCD_CLEAR, 8'd0, pkt_len == 0);
              for (int i = 0; i < pkt_len; i++)
                queue_action(ucd_pkg::ACT_LCD_CHAR, payload_buf[i], i + 1 == pkt_len);
            end
            default: ;
          endcase
        end
      end
      default: begin
        if (b == start_marker) frame_phase = FR_TYPE;
        else if (b >= ucd_pkg::SENSOR_FIRST && b <= ucd_pkg::SENSOR_LAST)
          queue_action(ucd_pkg::ACT_SENSOR, b, 1'b1);
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    deframe_byte(b);
    items_sent++;
  endtask

  function automatic byte_q_t random_payload(input int n);
    byte_q_t q;
    for (int i = 0; i < n; i++)
      q.push_back(($urandom_range(7) == 0) ? 8'h00 : 8'($urandom));
    return q;
  endfunction

  task automatic send_packet(input logic [7:0] kind, input byte_q_t payload,
                             input bit bad_check, input bit truncate = 1'b0);
    logic [7:0] chk;
    int n;
    chk = kind ^ 8'(payload.size());
    n = truncate ? payload.size() / 2 : payload.size();
    send_byte(start_marker);
    send_byte(kind);
    send_byte(8'(payload.size()));
    for (int i = 0; i < n; i++) begin
      send_byte(payload[i]);
      chk = chk ^ payload[i];
    end
    foreach (payload[i]) if (i >= n) chk = chk ^ payload[i];
    if (bad_check) chk = chk ^ 8'($urandom_range(1, 255));
    if (!truncate) send_byte(chk);
  endtask

  task automatic wait_drained();
    while (expected_actions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_marker(input logic [7:0] v);
    while (frame_phase != FR_IDLE) send_byte(8'h00);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    start_marker = v;
    marker_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_sensor_requests();
    send_byte(8'h00);
    send_byte(ucd_pkg::SENSOR_FIRST);
    send_byte(8'h02);
    send_byte(ucd_pkg::SENSOR_LAST);
    send_byte(8'h04);
    send_byte(8'hFF);
  endtask

  task automatic test_actuator_commands();
    send_packet(ucd_pkg::TYPE_RELAY, '{8'h00}, 1'b0);
    send_packet(ucd_pkg::TYPE_RELAY, '{8'h80}, 1'b0);
    send_packet(ucd_pkg::TYPE_LED, '{8'hFF}, 1'b0);
    send_packet(ucd_pkg::TYPE_SERVO, '{8'h5A, 8'hC3}, 1'b0);
  endtask

  task automatic test_lcd_text();
    send_packet(ucd_pkg::TYPE_LCD, '{}, 1'b0);
    send_packet(ucd_pkg::TYPE_LCD, '{8'h41}, 1'b0);
    send_packet(ucd_pkg::TYPE_LCD, random_payload(PAYLOAD_DEPTH), 1'b0);
  endtask

  task automatic test_rejected_packets();
    send_packet(ucd_pkg::TYPE_LED, '{8'h33}, 1'b1);
    send_packet(8'h14, '{8'h01}, 1'b0);
    send_packet(8'h00, '{}, 1'b0);
    send_packet(ucd_pkg::TYPE_RELAY, '{}, 1'b0);
    send_packet(ucd_pkg::TYPE_LED, '{}, 1'b0);
    send_packet(ucd_pkg::TYPE_SERVO, '{}, 1'b0);
    send_packet(ucd_pkg::TYPE_LCD, random_payload(PAYLOAD_DEPTH + 1), 1'b0);
    send_packet(ucd_pkg::TYPE_LCD, '{8'h7E, 8'h21}, 1'b0);
  endtask

  task automatic test_start_marker();
    write_marker(ucd_pkg::SENSOR_FIRST);
    send_byte(8'h02);
    send_packet(ucd_pkg::TYPE_RELAY, '{8'h01}, 1'b0);
    write_marker(8'h00);
    send_packet(ucd_pkg::TYPE_SERVO, '{8'hB4}, 1'b0);
    send_byte(ucd_pkg::SENSOR_LAST);
    write_marker(8'hFF);
    send_packet(ucd_pkg::TYPE_LED, '{8'h7F}, 1'b0);
    send_byte(ucd_pkg::START_MARKER_RST);
    write_marker(8'($urandom));
    send_packet(ucd_pkg::TYPE_LCD, random_payload(3), 1'b0);
    write_marker(ucd_pkg::START_MARKER_RST);
  endtask

  task automatic test_random_traffic();
    int send_pct[4] = '{0, 61, 0, 6};
    int stall_pct[4] = '{0, 0, 61, 6};
    logic [7:0] known_types[4] = '{ucd_pkg::TYPE_RELAY, ucd_pkg::TYPE_LED,
                                   ucd_pkg::TYPE_SERVO, ucd_pkg::TYPE_LCD};
    int start_count;
    int pick;
    logic [7:0] kind;
    int len;
    for (int p = 0; p < 4; p++) begin
      if (p != 0)
        write_marker(($urandom_range(1) == 0) ? ucd_pkg::START_MARKER_RST : 8'($urandom));
      send_idle_pct = send_pct[p];
      recv_stall_pct = stall_pct[p];
      start_count = items_sent;
      while (items_sent - start_count < 4) begin
        pick = $urandom_range(99);
        kind = known_types[$urandom_range(3)];
        if (kind == ucd_pkg::TYPE_LCD)
          len = ($urandom_range(9) == 0) ? PAYLOAD_DEPTH : $urandom_range(0, 5);
        else
          len = ($urandom_range(4) == 0) ? $urandom_range(0, 3) : 1;
        if (pick < 60) begin
          send_packet(kind, random_payload(len), 1'b0);
        end else if (pick < 70) begin
          send_packet(kind, random_payload(len), 1'b1);
        end else if (pick < 78) begin
          send_packet(8'($urandom), random_payload($urandom_range(0, 4)), 1'b0);
        end else if (pick < 84) begin
          send_packet(kind, random_payload($urandom_range(PAYLOAD_DEPTH + 1, 24)), 1'b0);
        end else if (pick < 92) begin
          send_byte(($urandom_range(1) == 0) ? 8'($urandom_range(1, 3)) : 8'($urandom));
        end else begin
          send_packet(kind, random_payload($urandom_range(1, 6)), 1'b0, 1'b1);
        end
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    cfg_valid_i = 1'b0;
    cfg_data_i = 8'h00;
    start_marker = ucd_pkg::START_MARKER_RST;
    frame_phase = FR_IDLE;
    pkt_type = 8'h00;
    pkt_len = 8'h00;
    byte_cnt = 8'h00;
    run_xor = 8'h00;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_sensor_requests();
    test_actuator_commands();
    test_lcd_text();
    test_rejected_packets();
    test_start_marker();
    test_random_traffic();

    wait_drained();
    $display("Covered sensor bytes, relay/LED/servo/LCD packets, rejected packets and %0d %s",
             marker_writes, "start marker writes");
    $display("%0d input items sent, %0d results checked under four idle/stall patterns",
             items_sent, results_checked);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
